[sv/qninv_pkg.sv]
// ---------------------------------------------------------------------------
// qninv_pkg : shared types and constants for the quadratic number inverter
// Payload structs, the multiplier control struct and the default word width.
// ---------------------------------------------------------------------------
package qninv_pkg;

   localparam int unsigned WORD_BITS_DEF = 64;

   typedef struct packed {
      logic signed [63:0] num_a;
      logic signed [63:0] num_b;
      logic signed [63:0] den_d;
   } req_type;

   typedef struct packed {
      logic signed [63:0] inv_a;
      logic signed [63:0] inv_b;
      logic signed [63:0] inv_d;
      logic               zero_gcd;
   } rsp_type;

   // multiplier control: start pulse and busy flag; the operands come as vectors
   typedef struct packed {
      logic start;
      logic busy;
   } mul_ctl_type;

endpackage

[sv/qninv_mul.sv]
// ---------------------------------------------------------------------------
// qninv_mul : bit-serial wrapping multiplier
// Shift-and-add over the multiplier word, one bit a cycle, result wraps
// at the operand width.
// ---------------------------------------------------------------------------
module qninv_mul
   import qninv_pkg::*;
#(
   parameter int unsigned WIDTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_x,
   input  logic [WIDTH-1:0] op_y,
   output mul_ctl_type      ctl,
   output logic [WIDTH-1:0] product
);

   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] x_ff, x_in, y_ff, y_in, p_ff, p_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = op_x;
         y_in    = op_y;
         p_in    = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff[0]) begin
            p_in = p_ff + x_ff;
         end
         x_in   = x_ff << 1;
         y_in   = y_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         // stop early once no multiplier bits remain
         if (cnt_ff == CW'(1) || (y_ff >> 1) == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      p_ff <= p_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign product   = p_ff;

endmodule

[sv/quadratic_number_invert_normalize_core.sv]
// ---------------------------------------------------------------------------
// quadratic_number_invert_normalize_core : inverse of (a + b*sqrt(D))/d
// Forms (a*d - b*d*sqrt(D)) / (a^2 - b^2*D), fixes the sign of the
// denominator and reduces the three terms by their common gcd.
// ---------------------------------------------------------------------------
// One item is in flight at a time; req_stall stays high from acceptance until
// the result beat has been taken. The item runs through five products on a
// shared bit-serial multiplier (finishing early when the multiplier operand
// is small and positive), a binary gcd in two passes over the three
// magnitudes (one shift or subtract a cycle), and three restoring divisions
// by the gcd, so small operands finish sooner.
// A zero gcd (all three terms zero) gives zero terms and sets zero_gcd.
module quadratic_number_invert_normalize_core
   import qninv_pkg::*;
#(
   parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int unsigned DW = 2 * WORD_BITS;
   localparam int unsigned SW = $clog2(DW + 1);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_MUL   = 12'b000000000010,
      ST_SIGN  = 12'b000000000100,
      ST_GPREP = 12'b000000001000,
      ST_GEVEN = 12'b000000010000,
      ST_GUODD = 12'b000000100000,
      ST_GLOOP = 12'b000001000000,
      ST_GNEXT = 12'b000010000000,
      ST_GSHL  = 12'b000100000000,
      ST_DIV   = 12'b001000000000,
      ST_DNEXT = 12'b010000000000,
      ST_OUT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [WORD_BITS-1:0] disc_ff;
   logic [DW-1:0] a_ff, a_in, b_ff, b_in, d_ff, d_in, disc_wide;
   logic [DW-1:0] na_ff, na_in, nb_ff, nb_in, nd_ff, nd_in;
   logic [DW-1:0] u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [SW-1:0] sh_ff, sh_in;
   logic [2:0]    step_ff, step_in;
   logic [1:0]    gpass_ff, gpass_in;
   logic [1:0]    dsel_ff, dsel_in;
   logic [DW-1:0] q_ff, q_in, r_ff, r_in, n_ff, n_in;
   logic [SW-1:0] dcnt_ff, dcnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       out_ff, out_in;

   logic          mul_start;
   logic [DW-1:0] mul_x, mul_y, mul_p;
   mul_ctl_type   mul_ctl;

   qninv_mul #(.WIDTH(DW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_x    (mul_x),
      .op_y    (mul_y),
      .ctl     (mul_ctl),
      .product (mul_p)
   );

   function automatic logic [DW-1:0] sx(input logic [63:0] v);
      logic [WORD_BITS-1:0] w;
      w = v[WORD_BITS-1:0];
      return {{(DW - WORD_BITS){w[WORD_BITS-1]}}, w};
   endfunction

   function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
      return v[DW-1] ? (~v + DW'(1)) : v;
   endfunction

   function automatic logic [63:0] sx64(input logic [DW-1:0] v);
      return 64'($signed(v[WORD_BITS-1:0]));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         disc_ff <= '0;
      end else if (csr_write) begin
         disc_ff <= csr_wdata[WORD_BITS-1:0];
      end
   end

   assign disc_wide = {{(DW - WORD_BITS){disc_ff[WORD_BITS-1]}}, disc_ff};

   logic [DW-1:0] dv_src, r_sh, r_sub;
   logic          r_carry, r_ge;

   always_comb begin
      case (dsel_ff)
         2'd0:    dv_src = na_ff;
         2'd1:    dv_src = nb_ff;
         default: dv_src = nd_ff;
      endcase
      r_carry = r_ff[DW-1];
      r_sh    = {r_ff[DW-2:0], n_ff[DW-1]};
      r_ge    = r_carry || (r_sh >= g_ff);
      r_sub   = r_sh - g_ff;
   end

   always_comb begin
      state_in     = state_ff;
      a_in = a_ff; b_in = b_ff; d_in = d_ff;
      na_in = na_ff; nb_in = nb_ff; nd_in = nd_ff;
      u_in = u_ff; v_in = v_ff; g_in = g_ff; sh_in = sh_ff;
      step_in = step_ff; gpass_in = gpass_ff; dsel_in = dsel_ff;
      q_in = q_ff; r_in = r_ff; n_in = n_ff; dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      mul_start    = 1'b0;
      mul_x        = a_ff;
      mul_y        = d_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // hold the input while the previous result beat waits
            if (req_valid && !rsp_valid_ff) begin
               a_in    = sx(req_data.num_a);
               b_in    = sx(req_data.num_b);
               d_in    = sx(req_data.den_d);
               step_in = 3'd0;
               state_in = ST_MUL;
               mul_start = 1'b1;
               mul_x = sx(req_data.num_a);
               mul_y = sx(req_data.den_d);
            end
         end
         // products: a*d, b*d, a*a, b*b, (b*b)*D
         ST_MUL: begin
            if (!mul_ctl.busy && !mul_start) begin
               step_in = step_ff + 3'd1;
               mul_start = 1'b1;
               case (step_ff)
                  3'd0: begin
                     na_in = mul_p;
                     mul_x = b_ff; mul_y = d_ff;
                  end
                  3'd1: begin
                     nb_in = ~mul_p + DW'(1);
                     mul_x = a_ff; mul_y = a_ff;
                  end
                  3'd2: begin
                     nd_in = mul_p;
                     mul_x = b_ff; mul_y = b_ff;
                  end
                  3'd3: begin
                     mul_x = mul_p; mul_y = disc_wide;
                  end
                  default: begin
                     nd_in = nd_ff - mul_p;
                     mul_start = 1'b0;
                     state_in = ST_SIGN;
                  end
               endcase
            end
         end
         ST_SIGN: begin
            if (nd_ff[DW-1]) begin
               na_in = ~na_ff + DW'(1);
               nb_in = ~nb_ff + DW'(1);
               nd_in = ~nd_ff + DW'(1);
            end
            g_in     = mag(na_ff[DW-1] ^ nd_ff[DW-1] ? ~na_ff + DW'(1) : na_ff);
            gpass_in = 2'd1;
            state_in = ST_GPREP;
         end
         // gcd(g, next magnitude)
         ST_GPREP: begin
            u_in  = g_ff;
            v_in  = (gpass_ff == 2'd1) ? mag(nb_ff) : mag(nd_ff);
            sh_in = '0;
            if (g_ff == '0) begin
               g_in = (gpass_ff == 2'd1) ? mag(nb_ff) : mag(nd_ff);
               state_in = ST_GNEXT;
            end else if (v_in == '0) begin
               state_in = ST_GNEXT;
            end else begin
               state_in = ST_GEVEN;
            end
         end
         ST_GEVEN: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1; v_in = v_ff >> 1; sh_in = sh_ff + SW'(1);
            end else begin
               state_in = ST_GUODD;
            end
         end
         ST_GUODD: begin
            if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else begin
               state_in = ST_GLOOP;
            end
         end
         ST_GLOOP: begin
            if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (v_ff < u_ff) begin
               u_in = v_ff;
               v_in = u_ff - v_ff;
               if (u_ff - v_ff == '0) state_in = ST_GSHL;
            end else begin
               v_in = v_ff - u_ff;
               if (v_ff - u_ff == '0) state_in = ST_GSHL;
            end
         end
         ST_GSHL: begin
            if (sh_ff != '0) begin
               u_in = u_ff << 1; sh_in = sh_ff - SW'(1);
            end else begin
               g_in = u_ff;
               state_in = ST_GNEXT;
            end
         end
         ST_GNEXT: begin
            if (gpass_ff == 2'd1) begin
               gpass_in = 2'd2;
               state_in = ST_GPREP;
            end else if (g_ff == '0) begin
               out_in = '0;
               out_in.zero_gcd = 1'b1;
               state_in = ST_OUT;
            end else begin
               dsel_in = 2'd0;
               n_in = mag(na_ff); q_in = '0; r_in = '0; dcnt_in = SW'(DW);
               state_in = ST_DIV;
            end
         end
         // restoring division, one quotient bit a cycle
         ST_DIV: begin
            n_in = n_ff << 1;
            r_in = r_ge ? r_sub : r_sh;
            q_in = {q_ff[DW-2:0], r_ge};
            dcnt_in = dcnt_ff - SW'(1);
            if (dcnt_ff == SW'(1)) state_in = ST_DNEXT;
         end
         ST_DNEXT: begin
            case (dsel_ff)
               2'd0: out_in.inv_a = sx64(dv_src[DW-1] ? ~q_ff + DW'(1) : q_ff);
               2'd1: out_in.inv_b = sx64(dv_src[DW-1] ? ~q_ff + DW'(1) : q_ff);
               default: out_in.inv_d = sx64(dv_src[DW-1] ? ~q_ff + DW'(1) : q_ff);
            endcase
            out_in.zero_gcd = 1'b0;
            if (dsel_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               dsel_in = dsel_ff + 2'd1;
               n_in = mag(dsel_ff == 2'd0 ? nb_ff : nd_ff);
               q_in = '0; r_in = '0; dcnt_in = SW'(DW);
               state_in = ST_DIV;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff <= a_in; b_ff <= b_in; d_ff <= d_in;
      na_ff <= na_in; nb_ff <= nb_in; nd_ff <= nd_in;
      u_ff <= u_in; v_ff <= v_in; g_ff <= g_in; sh_ff <= sh_in;
      step_ff <= step_in; gpass_ff <= gpass_in; dsel_ff <= dsel_in;
      q_ff <= q_in; r_ff <= r_in; n_ff <= n_in; dcnt_ff <= dcnt_in;
      out_ff <= out_in;
   end

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[sv/qninv_checker.sv]
// ---------------------------------------------------------------------------
// qninv_checker : port-level checks for the quadratic number inverter
// Watches handshakes and flag consistency on the top-level ports.
// ---------------------------------------------------------------------------
module qninv_checker
   import qninv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // a zero gcd forces zero terms
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_gcd |->
         rsp_data.inv_a == '0 && rsp_data.inv_b == '0 && rsp_data.inv_d == '0)
      else $error("zero gcd with nonzero terms");

   // accepting an item closes the input until its result is out
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input reopened while busy");

   // hold the input while a result beat waits
   a_rsp_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result beat waits");

endmodule

bind quadratic_number_invert_normalize_core qninv_checker u_qninv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench : self-checking bench for quadratic_number_invert_normalize_core
// Drives quadratic numbers through the inverter under several discriminants
// and idling mixes, predicts each normalized inverse in 128-bit arithmetic
// and compares every result beat field by field in order.
// ---------------------------------------------------------------------------
module testbench;
   import qninv_pkg::*;

   localparam int unsigned STALL_LIMIT = 200000;
   localparam int unsigned MAX_SHOWN   = 10;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [63:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;

   logic signed [63:0] field_disc;
   rsp_type            inverse_q[$];
   int unsigned        idle_pct;
   int unsigned        stall_pct;
   int unsigned        hold_left;
   int unsigned        mismatches;
   int unsigned        beats_in;
   int unsigned        beats_out;
   int unsigned        zero_seen;
   int unsigned        quiet_cycles;

   quadratic_number_invert_normalize_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [127:0] gcd_mag(logic [127:0] u, logic [127:0] v);
      logic [127:0] t;
      while (v != 0) begin
         t = u % v;
         u = v;
         v = t;
      end
      return u;
   endfunction

   function automatic rsp_type invert_quad(req_type r, logic signed [63:0] dl);
      logic signed [127:0] a, b, d, disc, na, nb, nd;
      logic [127:0]        ma, mb, md, g, q;
      rsp_type             o;
      a = r.num_a;
      b = r.num_b;
      d = r.den_d;
      disc = dl;
      na = a * d;
      nb = -(b * d);
      nd = a * a - b * b * disc;
      if (nd < 0) begin
         na = -na;
         nb = -nb;
         nd = -nd;
      end
      ma = (na < 0) ? -na : na;
      mb = (nb < 0) ? -nb : nb;
      md = (nd < 0) ? -nd : nd;
      g = gcd_mag(gcd_mag(ma, mb), md);
      o = '0;
      if (g == 0) begin
         o.zero_gcd = 1'b1;
         return o;
      end
      q = ma / g;
      o.inv_a = (na < 0) ? -q[63:0] : q[63:0];
      q = mb / g;
      o.inv_b = (nb < 0) ? -q[63:0] : q[63:0];
      q = md / g;
      o.inv_d = (nd < 0) ? -q[63:0] : q[63:0];
      return o;
   endfunction

   // receiver: long hold-off first, random stalls otherwise
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out <= beats_out + 1;
         if (inverse_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected result beat %p", rsp_data);
         end else begin
            want = inverse_q.pop_front();
            if (rsp_data.zero_gcd) zero_seen <= zero_seen + 1;
            if (rsp_data.inv_a !== want.inv_a || rsp_data.inv_b !== want.inv_b ||
                rsp_data.inv_d !== want.inv_d || rsp_data.zero_gcd !== want.zero_gcd) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("mismatch: expected a=%0d b=%0d d=%0d z=%0b got a=%0d b=%0d d=%0d z=%0b",
                           want.inv_a, want.inv_b, want.inv_d, want.zero_gcd,
                           rsp_data.inv_a, rsp_data.inv_b, rsp_data.inv_d,
                           rsp_data.zero_gcd);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_number(logic signed [63:0] a, logic signed [63:0] b,
                              logic signed [63:0] d);
      req_type item;
      item.num_a = a;
      item.num_b = b;
      item.den_d = d;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      inverse_q.push_back(invert_quad(item, field_disc));
      beats_in++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      wait (inverse_q.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_disc(logic signed [63:0] v);
      drain();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      field_disc = v;
   endtask

   function automatic logic signed [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic signed [63:0] rand_field();
      logic signed [63:0] v;
      case ($urandom_range(0, 5))
         0: v = 0;
         1, 2: v = $signed(64'($urandom_range(0, 2000))) - 1000;
         3: v = $signed(64'($urandom_range(0, 1 << 30))) - (1 << 29);
         default: v = rand_word();
      endcase
      return v;
   endfunction

   task automatic test_directed();
      logic signed [63:0] mx, mn;
      mx = 64'sh7fff_ffff_ffff_ffff;
      mn = 64'sh8000_0000_0000_0000;
      send_number(0, 0, 0);          // all zero: flag raised
      send_number(5, 0, 0);          // zero denominator in
      send_number(0, 0, 7);
      send_number(3, 4, 6);
      send_number(mx, mx, mx);
      send_number(mn, mn, mn);
      send_number(mn, mx, -1);
      send_number(-1, -1, -1);
      write_disc(5);
      send_number(0, 1, 1);          // negative new denominator
      send_number(2, 1, 3);
      send_number(6, 2, 4);
      write_disc(2);
      send_number(0, mn, 1);         // denominator wraps to most negative
      send_number(0, mn, mn);
      write_disc(mx);
      send_number(mx, mn, 3);
      send_number(1, 1, 1);
      write_disc(mn);
      send_number(1, 1, 1);
      send_number(mn, mn, 1);
      write_disc(-1);
      send_number(0, 1, -1);
      send_number(12, 18, 30);
   endtask

   task automatic test_pressure();
      hold_left = 4000;
      repeat (3) send_number(rand_field(), rand_field(), rand_field());
      drain();
      send_number(9, 3, 6);
      drain();                        // sender waits for every result
      send_number(-8, 4, 2);
   endtask

   task automatic test_random(int unsigned n);
      logic signed [63:0] k;
      for (int unsigned i = 0; i < n; i++) begin
         // scale by a common factor now and then so the gcd is non-trivial
         k = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(2, 64)) : 64'sd1;
         send_number(rand_field() * k, rand_field() * k, rand_field() * k);
      end
   endtask

   initial begin
      logic signed [63:0] discs[6];
      discs = '{64'sd0, 64'sd5, -64'sd3, 64'sh7fff_ffff_ffff_ffff,
                64'sh8000_0000_0000_0000, 64'sd13};
      reset = 1'b1;
      csr_write = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      field_disc = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      mismatches = 0;
      beats_in = 0;
      beats_out = 0;
      zero_seen = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_pressure();
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         write_disc((p < 6) ? discs[p] : rand_word());
         test_random(95);
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d numbers in, %0d inverses out, %0d zero-gcd cases",
               beats_in, beats_out, zero_seen);
      $display("discriminants: zero, small, both extremes and random; four idling mixes");
      if (mismatches == 0 && inverse_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
sv/qninv_pkg.sv
sv/qninv_mul.sv
sv/quadratic_number_invert_normalize_core.sv
sv/qninv_checker.sv
dv/testbench.sv
